>>> sv/mte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_pkg: shared types and constants for the cascaded multi-tap echo
// Field layout of the tap registers, fixed-point constants, digit size of
// the serial multiplier and the control word of the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mte_pkg;

  // Default values of the top-level parameters
  localparam int HISTORY_DEPTH_DEF = 8192;
  localparam int TAP_COUNT_DEF     = 5;
  localparam int SAMPLE_RATE_DEF   = 11025;
  localparam int SAMPLE_WIDTH_DEF  = 16;

  // Configuration registers
  localparam int NUM_TAP_REGS = 5;
  localparam int CFG_W        = 23;
  localparam int CFG_IDX_W    = 3;
  localparam logic [CFG_W-1:0] TAP_RESET = 23'd3276800;  // 50 ms, gain 0
  localparam int DLY_MSB      = 22;
  localparam int DLY_LSB      = 16;
  localparam int MS_W         = DLY_MSB - DLY_LSB + 1;

  // Delay conversion
  localparam int DELAY_MS_MIN  = 50;
  localparam int DELAY_MS_MAX  = 80;
  localparam int MS_PER_SECOND = 1000;
  localparam int DLY_SPAN      = DELAY_MS_MAX - DELAY_MS_MIN + 1;
  localparam int OFF_W         = $clog2(DLY_SPAN);
  localparam int CONV_W        = 11;   // holds 80 ms at the default sample rate

  // Fixed point
  localparam int GAIN_W    = 16;       // Q1.15
  localparam int Q15_FRAC  = 15;
  localparam int Q15_HALF  = 16384;
  localparam logic signed [GAIN_W:0] GAIN_ONE = 17'sd32768;
  localparam int ACC_GUARD = 19;       // accumulator is SAMPLE_WIDTH + this

  // Serial multiplier
  localparam int DIGIT_W = 4;

  typedef struct packed {
    logic load;    // preset the accumulator with the dry term
    logic start;   // start one product, added when complete
  } mac_ctrl_t;

endpackage

>>> sv/mte_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_mac: digit-serial multiply-accumulate
// Shifts the sample out one digit per cycle, most significant first, and
// folds each digit into the partial product; adds the product to the
// accumulator in the cycle after the last digit.
// ----------------------------------------------------------------------------
module mte_mac #(
  parameter int SAMPLE_WIDTH = mte_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  mte_pkg::mac_ctrl_t                                 ctrl_i,
  input  logic signed [SAMPLE_WIDTH+mte_pkg::ACC_GUARD-1:0]  init_i,
  input  logic signed [mte_pkg::GAIN_W-1:0]                  mcand_i,
  input  logic signed [SAMPLE_WIDTH-1:0]                     mplier_i,
  output logic                                               busy_o,
  output logic signed [SAMPLE_WIDTH+mte_pkg::ACC_GUARD-1:0]  acc_o
);

  localparam int ACC_W  = SAMPLE_WIDTH + mte_pkg::ACC_GUARD;
  localparam int DW     = mte_pkg::DIGIT_W;
  localparam int NDIG   = (SAMPLE_WIDTH + DW - 1) / DW;
  localparam int MB_W   = NDIG * DW;
  localparam int PROD_W = mte_pkg::GAIN_W + MB_W;
  localparam int CNT_W  = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic signed [mte_pkg::GAIN_W-1:0]    mcand_r;
  logic        [MB_W-1:0]               mplier_r;
  logic signed [PROD_W-1:0]             part_r;
  logic signed [PROD_W-1:0]             part_nxt;
  logic        [CNT_W-1:0]              cnt_r;
  logic                                 busy_r;
  logic                                 add_r;
  logic signed [ACC_W-1:0]              acc_r;
  logic        [DW-1:0]                 digit;
  logic signed [DW:0]                   digit_s;
  logic signed [mte_pkg::GAIN_W+DW:0]   pp;

  // Top digit carries the sign; the rest are plain magnitudes
  assign digit   = mplier_r[MB_W-1 -: DW];
  assign digit_s = (cnt_r == '0) ? $signed({digit[DW-1], digit}) : $signed({1'b0, digit});
  assign pp      = mcand_r * digit_s;
  assign part_nxt = (part_r <<< DW) + PROD_W'(pp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      add_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      add_r <= 1'b0;
      if (ctrl_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(NDIG - 1)) begin
          busy_r <= 1'b0;
          add_r  <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.start) begin
      mcand_r  <= mcand_i;
      mplier_r <= MB_W'(mplier_i);
      part_r   <= '0;
    end else if (busy_r) begin
      mplier_r <= mplier_r << DW;
      part_r   <= part_nxt;
    end
    if (ctrl_i.load) begin
      acc_r <= init_i;
    end else if (add_r) begin
      acc_r <= acc_r + ACC_W'(part_r);
    end
  end

  assign busy_o = busy_r | add_r;
  assign acc_o  = acc_r;

endmodule

>>> sv/mte_taps.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_taps: tap registers and cumulative tap table
// Holds the five tap registers and, after reset or any write, walks the
// taps once to build the cumulative delay and Q1.15 gain of each tap.
// ----------------------------------------------------------------------------
module mte_taps #(
  parameter int HISTORY_DEPTH = mte_pkg::HISTORY_DEPTH_DEF,
  parameter int TAP_COUNT     = mte_pkg::TAP_COUNT_DEF,
  parameter int SAMPLE_RATE   = mte_pkg::SAMPLE_RATE_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_we_i,
  input  logic [mte_pkg::CFG_IDX_W-1:0]               cfg_index_i,
  input  logic [mte_pkg::CFG_W-1:0]                   cfg_data_i,
  input  logic [((TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1)-1:0] tap_sel_i,
  output logic [$clog2(HISTORY_DEPTH)-1:0]            dly_o,
  output logic signed [mte_pkg::GAIN_W-1:0]           gain_o,
  output logic                                        ready_o
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int TAP_IW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int GW     = mte_pkg::GAIN_W;

  logic [mte_pkg::CFG_W-1:0]   tap_r [mte_pkg::NUM_TAP_REGS];
  logic [AW-1:0]               cum_dly_r  [TAP_COUNT];
  logic signed [GW-1:0]        cum_gain_r [TAP_COUNT];
  logic [mte_pkg::CONV_W-1:0]  conv_tab [mte_pkg::DLY_SPAN];

  logic                        prep_busy_r;
  logic [TAP_IW-1:0]           prep_cnt_r;
  logic [AW-1:0]               run_dly_r;
  logic signed [GW:0]          run_gain_r;

  logic [mte_pkg::CFG_W-1:0]   cur;
  logic [mte_pkg::MS_W-1:0]    ms;
  logic [mte_pkg::MS_W-1:0]    ms_c;
  logic [mte_pkg::OFF_W-1:0]   off;
  logic [AW:0]                 dsum;
  logic [AW-1:0]               dsat;
  logic signed [GW-1:0]        g;
  logic signed [2*GW:0]        gprod;
  logic signed [2*GW:0]        grnd;
  logic [2*GW-mte_pkg::Q15_FRAC:0] gsh;
  logic signed [GW-1:0]        gsat;

  // Samples per tap delay, one entry per millisecond from 50 to 80
  for (genvar gi = 0; gi < mte_pkg::DLY_SPAN; gi++) begin : g_conv
    localparam int unsigned ConvVal =
      ((mte_pkg::DELAY_MS_MIN + gi) * SAMPLE_RATE) / mte_pkg::MS_PER_SECOND;
    assign conv_tab[gi] = mte_pkg::CONV_W'(ConvVal);
  end

  assign cur = tap_r[mte_pkg::CFG_IDX_W'(prep_cnt_r)];
  assign ms  = cur[mte_pkg::DLY_MSB:mte_pkg::DLY_LSB];
  assign g   = $signed(cur[GW-1:0]);

  always_comb begin
    if (ms < mte_pkg::MS_W'(mte_pkg::DELAY_MS_MIN)) begin
      ms_c = mte_pkg::MS_W'(mte_pkg::DELAY_MS_MIN);
    end else if (ms > mte_pkg::MS_W'(mte_pkg::DELAY_MS_MAX)) begin
      ms_c = mte_pkg::MS_W'(mte_pkg::DELAY_MS_MAX);
    end else begin
      ms_c = ms;
    end
    off  = mte_pkg::OFF_W'(ms_c - mte_pkg::MS_W'(mte_pkg::DELAY_MS_MIN));
    dsum = {1'b0, run_dly_r} + (AW+1)'(conv_tab[off]);
    if (dsum > (AW+1)'(HISTORY_DEPTH - 1)) begin
      dsat = AW'(HISTORY_DEPTH - 1);
    end else begin
      dsat = dsum[AW-1:0];
    end
  end

  // Round the running gain product to Q1.15 and saturate
  assign gprod = run_gain_r * g;
  assign grnd  = gprod + (2*GW+1)'(mte_pkg::Q15_HALF);
  assign gsh   = grnd[2*GW:mte_pkg::Q15_FRAC];

  always_comb begin
    if (gsh[2*GW-mte_pkg::Q15_FRAC] && !(&gsh[2*GW-mte_pkg::Q15_FRAC:GW-1])) begin
      gsat = {1'b1, {(GW-1){1'b0}}};
    end else if (!gsh[2*GW-mte_pkg::Q15_FRAC] && (|gsh[2*GW-mte_pkg::Q15_FRAC:GW-1])) begin
      gsat = {1'b0, {(GW-1){1'b1}}};
    end else begin
      gsat = $signed(gsh[GW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mte_pkg::NUM_TAP_REGS; i++) begin
        tap_r[i] <= mte_pkg::TAP_RESET;
      end
      prep_busy_r <= 1'b1;
      prep_cnt_r  <= '0;
      run_dly_r   <= '0;
      run_gain_r  <= mte_pkg::GAIN_ONE;
    end else if (cfg_we_i) begin
      if (cfg_index_i < mte_pkg::CFG_IDX_W'(mte_pkg::NUM_TAP_REGS)) begin
        tap_r[cfg_index_i] <= cfg_data_i;
      end
      // restart the walk over the taps
      prep_busy_r <= 1'b1;
      prep_cnt_r  <= '0;
      run_dly_r   <= '0;
      run_gain_r  <= mte_pkg::GAIN_ONE;
    end else if (prep_busy_r) begin
      run_dly_r  <= dsat;
      run_gain_r <= (GW+1)'(gsat);
      if (prep_cnt_r == TAP_IW'(TAP_COUNT - 1)) begin
        prep_busy_r <= 1'b0;
      end else begin
        prep_cnt_r <= prep_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prep_busy_r && !cfg_we_i) begin
      cum_dly_r[prep_cnt_r]  <= dsat;
      cum_gain_r[prep_cnt_r] <= gsat;
    end
  end

  assign dly_o   = cum_dly_r[tap_sel_i];
  assign gain_o  = cum_gain_r[tap_sel_i];
  assign ready_o = !prep_busy_r;

endmodule

>>> sv/cascaded_multi_tap_echo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_multi_tap_echo_top: multi-tap echo on a signed sample stream
// Adds five cascaded echoes to each sample: tap k reads the sample from the
// cumulative delay of taps 1..k and weights it by their cumulative gain.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   in_sample_in
//   out      source     out_valid / out_ready out_sample_out, out_clipped
//   cfg      sink       cfg_we                cfg_index, cfg_data
//
// Each word runs through the digit-serial multiplier once per tap, NDIG being
// the number of 4-bit digits in a sample: each tap costs one history read,
// one load, NDIG digit steps and one accumulate.
// Reset, and every configuration write, rebuilds the cumulative tap table
// with in_ready low. History needs no clearing pass: entries not yet written
// since reset read as zero through the fill count.
// A result waiting on out_ready holds the next word in the final step; a new
// word is accepted as soon as the previous one is handed to the output.
// ----------------------------------------------------------------------------
module cascaded_multi_tap_echo_top #(
  parameter int HISTORY_DEPTH = mte_pkg::HISTORY_DEPTH_DEF,
  parameter int TAP_COUNT     = mte_pkg::TAP_COUNT_DEF,
  parameter int SAMPLE_RATE   = mte_pkg::SAMPLE_RATE_DEF,
  parameter int SAMPLE_WIDTH  = mte_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input word
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  // result word
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  output logic                           out_clipped,
  // configuration
  input  logic                           cfg_we,
  input  logic [mte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mte_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int TAP_IW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int ACC_W  = SAMPLE_WIDTH + mte_pkg::ACC_GUARD;
  localparam int FRAC   = mte_pkg::Q15_FRAC;
  localparam int Y_W    = ACC_W - FRAC;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [TAP_IW-1:0]              tap_r, tap_nxt;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic [AW-1:0]                  wp_r;
  logic                           wrapped_r;

  // history store and its read port
  logic [SAMPLE_WIDTH-1:0]        hist_mem [HISTORY_DEPTH];
  logic [SAMPLE_WIDTH-1:0]        rd_data_r;
  logic                           rd_ok_r;
  logic                           hist_re;
  logic                           hist_we;
  logic [AW:0]                    diff;
  logic [AW-1:0]                  rd_idx;
  logic                           rd_ok;

  // tap table
  logic [AW-1:0]                  tap_dly;
  logic signed [mte_pkg::GAIN_W-1:0] tap_gain;
  logic                           taps_ready;

  // multiply-accumulate
  mte_pkg::mac_ctrl_t             mac_ctrl;
  logic signed [ACC_W-1:0]        mac_init;
  logic signed [SAMPLE_WIDTH-1:0] mac_mplier;
  logic                           mac_busy;
  logic signed [ACC_W-1:0]        acc;

  // output stage
  logic                           out_load;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_clipped_r;
  logic [ACC_W-1:0]               rnd;
  logic [Y_W-1:0]                 y_full;
  logic [Y_W-SAMPLE_WIDTH:0]      y_hi;
  logic                           clip;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  mte_taps #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TAP_COUNT     (TAP_COUNT),
    .SAMPLE_RATE   (SAMPLE_RATE)
  ) u_taps (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .tap_sel_i   (tap_r),
    .dly_o       (tap_dly),
    .gain_o      (tap_gain),
    .ready_o     (taps_ready)
  );

  mte_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_i   (mac_ctrl),
    .init_i   (mac_init),
    .mcand_i  (tap_gain),
    .mplier_i (mac_mplier),
    .busy_o   (mac_busy),
    .acc_o    (acc)
  );

  // Dry term: sample in Q.15, preset before the first tap
  assign mac_init = $signed({{(ACC_W-SAMPLE_WIDTH-FRAC){in_sample_in[SAMPLE_WIDTH-1]}},
                             in_sample_in, {FRAC{1'b0}}});
  // Drop reads of entries never written since reset
  assign mac_mplier = rd_ok_r ? $signed(rd_data_r) : '0;

  // Read address: current position minus cumulative delay, modulo depth
  always_comb begin
    diff = {1'b0, wp_r} - {1'b0, tap_dly};
    if (diff[AW]) begin
      rd_idx = AW'(diff + (AW+1)'(HISTORY_DEPTH));
    end else begin
      rd_idx = diff[AW-1:0];
    end
    rd_ok = wrapped_r || (rd_idx < wp_r);
  end

  // Sequencer: one tap per pass through ADDR, LOAD and WAIT
  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    mac_ctrl  = '0;
    hist_re   = 1'b0;
    hist_we   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && taps_ready) begin
          mac_ctrl.load = 1'b1;
          tap_nxt       = '0;
          state_nxt     = ST_ADDR;
        end
      end
      ST_ADDR: begin
        hist_re   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        mac_ctrl.start = 1'b1;
        state_nxt      = ST_WAIT;
      end
      ST_WAIT: begin
        if (!mac_busy) begin
          if (tap_r == TAP_IW'(TAP_COUNT - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            tap_nxt   = tap_r + 1'b1;
            state_nxt = ST_ADDR;
          end
        end
      end
      ST_DONE: begin
        // hold until the output register is free, then commit the sample
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          hist_we   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE) && taps_ready;

  // Round to nearest and saturate to the sample width
  always_comb begin
    rnd    = acc + ACC_W'(mte_pkg::Q15_HALF);
    y_full = rnd[ACC_W-1:FRAC];
    y_hi   = y_full[Y_W-1:SAMPLE_WIDTH-1];
    clip   = !((&y_hi) || !(|y_hi));
    if (!clip) begin
      y_sat = $signed(y_full[SAMPLE_WIDTH-1:0]);
    end else if (y_full[Y_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= '0;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      if (hist_we) begin
        if (wp_r == AW'(HISTORY_DEPTH - 1)) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r <= in_sample_in;
    end
    if (hist_re) begin
      rd_ok_r <= rd_ok;
    end
    if (out_load) begin
      out_sample_r  <= y_sat;
      out_clipped_r <= clip;
    end
  end

  // History memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp_r] <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_re) begin
      rd_data_r <= hist_mem[rd_idx];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

endmodule

>>> sv/mte_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mte_chk: port-level checks for the cascaded multi-tap echo
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module mte_chk #(
  parameter int SAMPLE_WIDTH = mte_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input logic                           out_clipped,
  input logic                           cfg_we
);

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // a stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample_out) && $stable(out_clipped))
    else $error("result payload changed while stalled");

  // a clipped result sits at one of the rails
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> (out_sample_out == SMAX) || (out_sample_out == SMIN))
    else $error("clipped result not at a rail");

  // one word at a time: no accept in the cycle after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // a configuration write rebuilds the tap table before the next word
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input ready right after a configuration write");

endmodule

bind cascaded_multi_tap_echo_top mte_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_mte_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out),
  .out_clipped    (out_clipped),
  .cfg_we         (cfg_we)
);
